[rtl/slir_pkg.sv]
// shared constants, codes and types for the sorted list block
package slir_pkg;

	localparam int DEPTH    = 16;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 4;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_READ_OK   = 3'd4,
		ST_BAD_POS   = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_REMOVE
	} state_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

	// result produced by the sequencer, read value added at top level
	typedef struct packed {
		logic                we;
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic [COUNT_W-1:0]  removed;
	} ctrl_res_t;

	// one queued result item
	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic [VAL_W-1:0]    read_value;
		logic [COUNT_W-1:0]  removed;
	} res_t;

endpackage

[rtl/slir_cell.sv]
// one storage cell of the sorted chain: compare against the broadcast value and shift
module slir_cell
	import slir_pkg::*;
(
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    valid,
	input  logic                    tail,
	input  logic                    left_gt,
	input  logic signed [VAL_W-1:0] left_entry,
	input  logic signed [VAL_W-1:0] right_entry,
	output logic signed [VAL_W-1:0] entry,
	output logic                    gt,
	output logic                    eq
);

	logic signed [VAL_W-1:0] entry_q;
	logic                    lt;

	// compare results against the broadcast value
	assign gt    = valid && (value < entry_q);
	assign eq    = valid && (value == entry_q);
	assign lt    = entry_q < value;
	assign entry = entry_q;

	// insert shifts right from the insertion point, remove pulls left from the first match
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt || tail) begin
				entry_q <= value;
			end
		end else if (ctrl.rem) begin
			if (valid && !lt) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

[rtl/slir_ctrl.sv]
// sequencer: command decode, entry count, remove iteration and result codes
module slir_ctrl
	import slir_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        command,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic [POS_W-1:0]        position,
	input  logic                    any_eq,
	input  logic                    res_free,
	output cell_ctrl_t              cell_ctrl,
	output logic signed [VAL_W-1:0] cell_value,
	output logic [CNT_W-1:0]        count,
	output ctrl_res_t               res
);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        removed_q, removed_d;
	logic signed [VAL_W-1:0] value_q;
	logic                    acc;
	logic                    full;
	logic                    pos_ok;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign pos_ok = (32'(position) < 32'(count_q));
	assign acc    = in_valid && in_ready;
	assign count  = count_q;

	// cells see the live input while idle, the held value while removing
	assign cell_value = (state_q == S_REMOVE) ? value_q : in_value;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && (cmd_t'(command) == CMD_REMOVE)) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: begin
				if (!any_eq && res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs, count and removal tally
	always_comb begin
		in_ready      = 1'b0;
		cell_ctrl     = '0;
		count_d       = count_q;
		removed_d     = removed_q;
		res.we        = 1'b0;
		res.status    = ST_BAD_POS;
		res.removed   = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = res_free;
				case (cmd_t'(command))
					CMD_INSERT: begin
						res.we        = acc;
						cell_ctrl.ins = acc && !full;
						res.status    = full ? ST_FULL : ST_INSERTED;
						if (acc && !full) begin
							count_d = count_q + CNT_W'(1);
						end
					end
					CMD_REMOVE: begin
						if (acc) begin
							removed_d = '0;
						end
					end
					CMD_READ: begin
						res.we     = acc;
						res.status = pos_ok ? ST_READ_OK : ST_BAD_POS;
					end
					default: begin
						res.we     = acc;
						res.status = ST_BAD_POS;
					end
				endcase
			end
			S_REMOVE: begin
				if (any_eq) begin
					cell_ctrl.rem = 1'b1;
					count_d       = count_q - CNT_W'(1);
					removed_d     = removed_q + CNT_W'(1);
				end else begin
					res.we      = res_free;
					res.status  = (removed_q == '0) ? ST_NOT_FOUND : ST_REMOVED;
					res.removed = COUNT_W'(removed_q);
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		res.count = COUNT_W'(count_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			removed_q <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
		end
	end

	// held remove value
	always_ff @(posedge clk) begin
		if (acc) begin
			value_q <= in_value;
		end
	end

endmodule

[rtl/sorted_list_insert_remove.sv]
// top level of the sorted list: cell chain, sequencer, read select and result queue
//
// Keeps up to DEPTH signed 32-bit entries in ascending order with a count.
// Input items arrive on s_tvalid/s_tready: s_tuser carries the command
// (insert, remove all equal, read at position), s_tdata the value and position.
// Every input item gives exactly one result item on m_tvalid/m_tready:
// m_tuser carries the status code, m_tdata the entry count after the step,
// the read value and the number of entries removed.
// Insert and read finish in the accept cycle; the result is registered into
// the result queue. Insert shifts every entry above the new value by one
// cell in the accept cycle.
// Remove holds the value at accept; the cell chain then closes the gap one
// entry per cycle until no equal entry is left, then reports once the
// result queue has room. Insert and read take one item per cycle while the
// queue has room; a remove takes no new item until it has reported.
// Results pass through a two-entry queue, so one finished result can wait on a
// stalled receiver while the next item is accepted; with both entries held,
// s_tready stays low until m_tready takes one.
// Reset (arst_n low) empties the list and the result queue; entry storage is
// not cleared, only entries below the count are ever used.
module sorted_list_insert_remove
	import slir_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], position[35:32], zero fill
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // entry_count[4:0], read_value[36:5], removed_number[41:37], zero fill
	output logic [2:0]  m_tuser   // status[2:0]
);

	logic signed [VAL_W-1:0] in_value;
	logic [POS_W-1:0]        position;
	cell_ctrl_t              cell_ctrl;
	logic signed [VAL_W-1:0] cell_value;
	logic [CNT_W-1:0]        count;
	ctrl_res_t               cres;
	res_t                    res;
	logic                    res_free;
	logic                    any_eq;

	logic signed [VAL_W-1:0] entry [DEPTH];
	logic [DEPTH-1:0]        gt;
	logic [DEPTH-1:0]        eq;
	logic [DEPTH-1:0]        valid;
	logic [DEPTH-1:0]        tail;
	logic [VAL_W-1:0]        read_sel;

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic pop;

	assign in_value = s_tdata[31:0];
	assign position = s_tdata[35:32];

	slir_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.command    (s_tuser),
		.in_value   (in_value),
		.position   (position),
		.any_eq     (any_eq),
		.res_free   (res_free),
		.cell_ctrl  (cell_ctrl),
		.cell_value (cell_value),
		.count      (count),
		.res        (cres)
	);

	// chain of cells, each linked to its two neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    left_gt;
		logic signed [VAL_W-1:0] left_entry;
		logic signed [VAL_W-1:0] right_entry;

		assign valid[i] = (CNT_W'(i) < count);
		assign tail[i]  = (CNT_W'(i) == count);

		if (i == 0) begin : g_first
			assign left_gt    = 1'b0;
			assign left_entry = entry[i];
		end else begin : g_mid
			assign left_gt    = gt[i-1];
			assign left_entry = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = entry[i];
		end else begin : g_inner
			assign right_entry = entry[i+1];
		end

		slir_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl),
			.value       (cell_value),
			.valid       (valid[i]),
			.tail        (tail[i]),
			.left_gt     (left_gt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entry[i]),
			.gt          (gt[i]),
			.eq          (eq[i])
		);
	end

	assign any_eq = |eq;

	// read select over the cells
	always_comb begin
		read_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (32'(i) == 32'(position)) begin
				read_sel = read_sel | entry[i];
			end
		end
	end

	// result item assembly
	always_comb begin
		res.status     = cres.status;
		res.count      = cres.count;
		res.removed    = cres.removed;
		res.read_value = (cres.status == ST_READ_OK) ? read_sel : '0;
	end

	// two-entry result queue
	assign pop      = out_valid_q && m_tready;
	assign res_free = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= cres.we;
				end else begin
					out_valid_q <= cres.we;
				end
			end else if (cres.we) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (cres.we) begin
					skid_q <= res;
				end
			end else if (cres.we) begin
				out_q <= res;
			end
		end else if (cres.we) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// output port packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {6'd0, out_q.removed, out_q.read_value, out_q.count};

endmodule

[rtl/slir_chk.sv]
// port-level checks on the sorted list results, bound to the top level
module slir_chk
	import slir_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result item stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// removed count only on a successful remove
	a_removed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_REMOVED) |-> (m_tdata[41:37] == '0))
		else $error("removed count set outside a remove");

	// read value only on a successful read
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_READ_OK) |-> (m_tdata[36:5] == '0))
		else $error("read value set outside a read");

	// count never beyond capacity and status always a known code
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[4:0]) <= DEPTH) && (m_tuser <= ST_BAD_POS))
		else $error("count or status out of range");

endmodule

bind sorted_list_insert_remove slir_chk u_slir_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the sorted list insert, remove and read block
module testbench;
	import slir_pkg::*;

	// command code outside the defined set, answered like a read beyond the count
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1425;
	localparam int PHASE_LEN    = 40;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		bit               wait_drained;
	} list_op_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	list_op_t pending_ops[$];
	res_t     expected_replies[$];
	list_op_t shown_op;

	// shadow copy of the list contents
	logic signed [VAL_W-1:0] shadow_entries [DEPTH];
	int shadow_count = 0;

	int  total_ops   = 0;
	int  accepted_n  = 0;
	int  replied_n   = 0;
	int  fail_n      = 0;
	int  idle_cycles = 0;
	int  gap_left    = 0;
	int  stall_left  = 0;
	logic calm;

	sorted_list_insert_remove dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stretches with no idling on either side
	assign calm = ((accepted_n / 150) % 4) == 3;

	// apply one command to the shadow list and return its reply
	function automatic res_t apply_list_op(list_op_t op);
		res_t r;
		int i;
		int kept;
		logic signed [VAL_W-1:0] v;
		r.status     = ST_BAD_POS;
		r.read_value = '0;
		r.removed    = '0;
		v = op.value;
		case (op.command)
			CMD_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// equal entries stay ahead of the new one
					i = shadow_count;
					while (i > 0 && v < shadow_entries[i - 1]) begin
						shadow_entries[i] = shadow_entries[i - 1];
						i--;
					end
					shadow_entries[i] = v;
					shadow_count++;
					r.status = ST_INSERTED;
				end
			end
			CMD_REMOVE: begin
				kept = 0;
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_entries[i] != v) begin
						shadow_entries[kept] = shadow_entries[i];
						kept++;
					end
				end
				if (kept == shadow_count) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status  = ST_REMOVED;
					r.removed = COUNT_W'(shadow_count - kept);
					shadow_count = kept;
				end
			end
			CMD_READ: begin
				if (int'(op.position) < shadow_count) begin
					r.status     = ST_READ_OK;
					r.read_value = shadow_entries[op.position];
				end
			end
			default: begin
				r.status = ST_BAD_POS;
			end
		endcase
		r.count = COUNT_W'(shadow_count);
		return r;
	endfunction

	task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
			fail_n++;
		end
	endtask

	task automatic queue_op(logic [CMD_W-1:0] command, logic [VAL_W-1:0] value,
			logic [POS_W-1:0] position, bit wait_drained);
		list_op_t op;
		op.command      = command;
		op.value        = value;
		op.position     = position;
		op.wait_drained = wait_drained;
		pending_ops.push_back(op);
	endtask

	// mostly small values so inserts and removes meet, with extremes and wide values
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return $urandom;
			default: return VAL_W'(int'($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	// item driver: random gap after each item, some items wait for all replies
	always @(posedge clk or negedge arst_n) begin : drive_items
		bit fire;
		bit drained;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			gap_left   <= 0;
			accepted_n <= 0;
		end else begin
			fire    = s_tvalid && s_tready;
			drained = (accepted_n + int'(fire)) == (replied_n + int'(m_tvalid && m_tready));
			if (fire) begin
				expected_replies.push_back(apply_list_op(shown_op));
				accepted_n <= accepted_n + 1;
			end
			if (s_tvalid && !fire) begin
				// item still waiting to be taken
			end else if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ops.size() > 0 && (drained || !pending_ops[0].wait_drained)) begin
				shown_op <= pending_ops[0];
				s_tdata  <= {4'b0, pending_ops[0].position, pending_ops[0].value};
				s_tuser  <= pending_ops[0].command;
				s_tvalid <= 1'b1;
				gap_left <= calm ? 0 : $urandom_range(0, 4);
				void'(pending_ops.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// reply monitor with random stalls, checks each item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : check_replies
		res_t want;
		int draw;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
			replied_n  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				replied_n <= replied_n + 1;
				if (expected_replies.size() == 0) begin
					$error("reply with no item outstanding: status %0d", m_tuser);
					fail_n++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status", VAL_W'(want.status), VAL_W'(m_tuser));
					check_field("entry_count", VAL_W'(want.count), VAL_W'(m_tdata[4:0]));
					check_field("read_value", want.read_value, m_tdata[36:5]);
					check_field("removed_number", VAL_W'(want.removed), VAL_W'(m_tdata[41:37]));
				end
				draw = calm ? 0 : $urandom_range(0, 4);
				stall_left <= draw;
				m_tready   <= (draw == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= (stall_left == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int n;
		int phase;
		int kind;
		int pick;
		int ins_pct;
		int rem_pct;
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] pool [6];

		// empty list cases
		queue_op(CMD_READ, 32'h0, 4'd0, 1'b0);
		queue_op(CMD_REMOVE, 32'h0, 4'd0, 1'b0);
		queue_op(CMD_UNUSED, 32'hdead_beef, 4'd9, 1'b0);
		// extremes, duplicates, reads at both ends and just past the count
		queue_op(CMD_INSERT, 32'h7fff_ffff, 4'd0, 1'b0);
		queue_op(CMD_INSERT, 32'h8000_0000, 4'd15, 1'b0);
		queue_op(CMD_INSERT, 32'h0, 4'd0, 1'b0);
		queue_op(CMD_INSERT, 32'hffff_ffff, 4'd0, 1'b0);
		queue_op(CMD_INSERT, 32'd5, 4'd0, 1'b0);
		queue_op(CMD_INSERT, 32'd5, 4'd0, 1'b0);
		queue_op(CMD_INSERT, 32'd5, 4'd0, 1'b0);
		queue_op(CMD_READ, 32'hffff_ffff, 4'd0, 1'b0);
		queue_op(CMD_READ, 32'h0, 4'd6, 1'b0);
		queue_op(CMD_READ, 32'h0, 4'd7, 1'b0);
		queue_op(CMD_READ, 32'h0, 4'd3, 1'b0);
		queue_op(CMD_REMOVE, 32'd5, 4'd0, 1'b0);
		queue_op(CMD_REMOVE, 32'd5, 4'd0, 1'b0);
		queue_op(CMD_REMOVE, 32'h8000_0000, 4'd0, 1'b0);
		queue_op(CMD_READ, 32'h0, 4'd15, 1'b0);
		queue_op(CMD_UNUSED, 32'h0, 4'd0, 1'b0);

		// random phases: filling, draining, mixed, and one repeated value
		n = 0;
		phase = 0;
		while (n < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 3);
			pool[0] = pick_value();
			for (int k = 1; k < 6; k++)
				pool[k] = (kind == 3) ? pool[0] : pick_value();
			case (kind)
				0: begin ins_pct = 80; rem_pct = 5;  end
				1: begin ins_pct = 20; rem_pct = 50; end
				2: begin ins_pct = 45; rem_pct = 25; end
				default: begin ins_pct = 75; rem_pct = 10; end
			endcase
			for (int k = 0; k < PHASE_LEN && n < RANDOM_ITEMS; k++) begin
				pick  = $urandom_range(0, 99);
				value = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 5)];
				if (pick == 99)
					command = CMD_UNUSED;
				else if (pick < ins_pct)
					command = CMD_INSERT;
				else if (pick < ins_pct + rem_pct)
					command = CMD_REMOVE;
				else
					command = CMD_READ;
				queue_op(command, value, POS_W'($urandom_range(0, 15)),
					(k == 0) && (phase % 5 == 0));
				n++;
			end
			phase++;
		end
		total_ops = pending_ops.size();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_n < total_ops || replied_n < total_ops)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d replies never arrived", expected_replies.size());
			fail_n++;
		end
		if (fail_n == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/slir_pkg.sv
rtl/slir_cell.sv
rtl/slir_ctrl.sv
rtl/sorted_list_insert_remove.sv
rtl/slir_chk.sv
tb/testbench.sv
